FILE: rtl/spq_pkg.sv
// Shared types and codes for the stable priority queue.
// No dependencies; imported by spq_cell, stable_priority_queue and the testbench.
`default_nettype none

package spq_pkg;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  payload;
        logic [3:0]  prio;
    } entry_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;  // insert accepted (queue not full)
        logic pop;     // pop accepted (queue not empty)
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_INSERTED   = 2'd0,
        ST_POPPED     = 2'd1,
        ST_POP_EMPTY  = 2'd2,
        ST_INS_FULL   = 2'd3
    } status_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/stable_priority_queue.sv
// Top level of the stable priority queue: a chain of spq_cell slots, the fill
// counter and the registered result port. Depends on spq_pkg and spq_cell.
`default_nettype none

// Bounded priority queue of DEPTH entries kept sorted in a row of cells, head
// in cell zero; lower priority values leave first, equal ones in arrival order.
// Each transaction (start high while busy low) is an insert or a pop and gives
// exactly one result, shown with done high for one cycle, on the cycle after
// start. Every cell updates in the same cycle, so a transaction can be issued
// on every clock; busy stays low. Results cannot be stalled by the receiver.
// fill_level reports the count after the transaction, modulo 64. An insert into
// a full queue is refused with status 3; a pop on an empty queue gives status 2.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [15:0] reg_no,
    input  wire logic [7:0]  age,
    input  wire logic [3:0]  priority_req,
    output logic             done,
    output logic [1:0]       status,
    output logic [15:0]      out_reg_no,
    output logic [7:0]       out_age,
    output logic [3:0]       out_priority,
    output logic [5:0]       fill_level
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    status_t       status_reg;
    status_t       status_next;
    entry_t        result_reg;
    entry_t        result_next;

    logic          full;
    logic          empty;
    cell_ctrl_t    ctrl;
    entry_t        new_entry;
    entry_t        cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_keep;
    logic [DEPTH-1:0] cell_occ;

    assign busy  = 1'b0;
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign new_entry.id      = reg_no;
    assign new_entry.payload = age;
    assign new_entry.prio    = priority_req;

    assign ctrl.insert = start && (req_type == REQ_INSERT) && !full;
    assign ctrl.pop    = start && (req_type == REQ_POP) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign cell_occ[gi] = (CW'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                spq_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .new_entry   (new_entry),
                    .occupied    (cell_occ[gi]),
                    .left_keep   (1'b1),
                    .left_entry  (new_entry),
                    .right_entry ((DEPTH > 1) ? cell_entry[(DEPTH > 1) ? 1 : 0]
                                              : cell_entry[0]),
                    .entry       (cell_entry[gi]),
                    .keep        (cell_keep[gi])
                );
            end
            else if (gi == DEPTH - 1)
            begin : g_tail
                spq_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .new_entry   (new_entry),
                    .occupied    (cell_occ[gi]),
                    .left_keep   (cell_keep[gi-1]),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (cell_entry[gi]),
                    .entry       (cell_entry[gi]),
                    .keep        (cell_keep[gi])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .new_entry   (new_entry),
                    .occupied    (cell_occ[gi]),
                    .left_keep   (cell_keep[gi-1]),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (cell_entry[gi+1]),
                    .entry       (cell_entry[gi]),
                    .keep        (cell_keep[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        result_next = '0;
        if (start)
        begin
            unique case (req_type)
                REQ_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_INS_FULL;
                    end
                    else
                    begin
                        status_next = ST_INSERTED;
                        count_next  = count_reg + CW'(1);
                    end
                end
                REQ_POP:
                begin
                    if (empty)
                    begin
                        status_next = ST_POP_EMPTY;
                    end
                    else
                    begin
                        status_next = ST_POPPED;
                        result_next = cell_entry[0];
                        count_next  = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_INSERTED;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= start;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_reg_no   = result_reg.id;
    assign out_age      = result_reg.payload;
    assign out_priority = result_reg.prio;

    generate
        if (CW >= 6)
        begin : g_fill_trunc
            assign fill_level = count_reg[5:0];
        end
        else
        begin : g_fill_ext
            assign fill_level = 6'(count_reg);
        end
    endgenerate

endmodule

`default_nettype wire

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and decides each cycle whether
// to hold, take the new entry, take its left neighbor or take its right one.
// Depends on spq_pkg.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     new_entry,
    input  wire logic       occupied,
    input  wire logic       left_keep,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output logic            keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // Entry stays in place on insert when it is served no later than the new one
    assign keep  = occupied && (entry_reg.prio <= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.insert)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: tb/stable_priority_queue_tb.sv
// Testbench for stable_priority_queue: a queued request driver, a result monitor
// and a sorted-list predictor of the queue. Depends on spq_pkg and the RTL top.
`default_nettype none

module stable_priority_queue_tb;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 4;

    typedef struct {
        logic        kind;
        logic [15:0] id;
        logic [7:0]  age;
        logic [3:0]  prio;
        bit          hold;   // wait until every result is back before issuing
    } request_t;

    typedef struct {
        status_t     status;
        logic [15:0] id;
        logic [7:0]  age;
        logic [3:0]  prio;
        logic [5:0]  fill;
    } queue_result_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic        req_type     = 1'b0;
    logic [15:0] reg_no       = '0;
    logic [7:0]  age          = '0;
    logic [3:0]  priority_req = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [15:0] out_reg_no;
    logic [7:0]  out_age;
    logic [3:0]  out_priority;
    logic [5:0]  fill_level;

    request_t      pending_requests[$];
    queue_result_t expected_results[$];
    entry_t        held_entries[DEPTH];
    int            held_count  = 0;
    int            issued      = 0;
    int            total_items = 0;
    int            fail_count  = 0;
    int            cycle_count = 0;

    stable_priority_queue #(.DEPTH(DEPTH)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .reg_no       (reg_no),
        .age          (age),
        .priority_req (priority_req),
        .done         (done),
        .status       (status),
        .out_reg_no   (out_reg_no),
        .out_age      (out_age),
        .out_priority (out_priority),
        .fill_level   (fill_level)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one request to the sorted list and queue the result it gives
    task automatic serve_request(input logic kind, input logic [15:0] id,
                                 input logic [7:0] pay, input logic [3:0] prio);
        queue_result_t r;
        entry_t        e;
        int            pos;
        r.status = ST_INSERTED;
        r.id     = '0;
        r.age    = '0;
        r.prio   = '0;
        if (kind == REQ_INSERT)
        begin
            if (held_count >= DEPTH)
                r.status = ST_INS_FULL;
            else
            begin
                e.id      = id;
                e.payload = pay;
                e.prio    = prio;
                pos = 0;
                // go past every entry of equal or lower value to keep FIFO order
                while (pos < held_count && held_entries[pos].prio <= prio)
                    pos++;
                for (int k = held_count; k > pos; k--)
                    held_entries[k] = held_entries[k - 1];
                held_entries[pos] = e;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
                r.status = ST_POP_EMPTY;
            else
            begin
                r.status = ST_POPPED;
                r.id     = held_entries[0].id;
                r.age    = held_entries[0].payload;
                r.prio   = held_entries[0].prio;
                for (int k = 1; k < held_count; k++)
                    held_entries[k - 1] = held_entries[k];
                held_count--;
            end
        end
        r.fill = 6'(held_count);
        expected_results.push_back(r);
    endtask

    task automatic add_request(input logic kind, input logic [15:0] id,
                               input logic [7:0] pay, input logic [3:0] prio,
                               input bit hold);
        request_t q;
        q.kind = kind;
        q.id   = id;
        q.age  = pay;
        q.prio = prio;
        q.hold = hold;
        pending_requests.push_back(q);
    endtask

    // Driver: record the accepted transaction, then present the next request
    always @(posedge clk)
    begin
        request_t nxt;
        int       idle_pct;
        int       phase;
        bit       go;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                serve_request(req_type, reg_no, age, priority_req);
                issued++;
            end
            if (start && busy)
                go = 0;  // hold the current transaction
            else
            begin
                phase = (total_items > 0) ? (issued * 4) / total_items : 0;
                case (phase)
                    1:       idle_pct = 52;
                    3:       idle_pct = 37;
                    default: idle_pct = 0;
                endcase
                go = pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct;
                if (go && pending_requests[0].hold &&
                    (start || done || expected_results.size() != 0))
                    go = 0;
                if (go)
                begin
                    nxt = pending_requests.pop_front();
                    start        <= 1'b1;
                    req_type     <= nxt.kind;
                    reg_no       <= nxt.id;
                    age          <= nxt.age;
                    priority_req <= nxt.prio;
                end
                else
                begin
                    // idle: leave noise on the fields
                    start        <= 1'b0;
                    req_type     <= 1'($urandom);
                    reg_no       <= 16'($urandom);
                    age          <= 8'($urandom);
                    priority_req <= 4'($urandom);
                end
            end
        end
    end

    // Monitor: results come one per done cycle and cannot be stalled
    always @(posedge clk)
    begin
        queue_result_t x;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no transaction pending: status %0d", status);
                fail_count++;
            end
            else
            begin
                x = expected_results.pop_front();
                if (status !== x.status)
                begin
                    $error("status: expected %0d, actual %0d", x.status, status);
                    fail_count++;
                end
                if (out_reg_no !== x.id)
                begin
                    $error("out_reg_no: expected %0h, actual %0h", x.id, out_reg_no);
                    fail_count++;
                end
                if (out_age !== x.age)
                begin
                    $error("out_age: expected %0h, actual %0h", x.age, out_age);
                    fail_count++;
                end
                if (out_priority !== x.prio)
                begin
                    $error("out_priority: expected %0d, actual %0d", x.prio, out_priority);
                    fail_count++;
                end
                if (fill_level !== x.fill)
                begin
                    $error("fill_level: expected %0d, actual %0d", x.fill, fill_level);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int mode;
        int seg_len;
        int ins_pct;
        int prio_lo;
        int prio_hi;
        int made;
        bit is_ins;

        // directed: empty pop, field extremes, ties, then drain past empty
        add_request(REQ_POP,    16'h0000, 8'h00, 4'h0, 0);
        add_request(REQ_INSERT, 16'hFFFF, 8'hFF, 4'hF, 0);
        add_request(REQ_INSERT, 16'h0000, 8'h00, 4'h0, 0);
        add_request(REQ_INSERT, 16'h1234, 8'h55, 4'h7, 0);
        add_request(REQ_INSERT, 16'h0002, 8'hAA, 4'h7, 0);
        add_request(REQ_INSERT, 16'h0003, 8'h01, 4'h7, 0);
        add_request(REQ_INSERT, 16'h0004, 8'h80, 4'h0, 0);
        add_request(REQ_INSERT, 16'h8000, 8'h7F, 4'hF, 0);
        add_request(REQ_POP,    16'hFFFF, 8'hFF, 4'hF, 1);
        for (int i = 0; i < 7; i++)
            add_request(REQ_POP, 16'($urandom), 8'($urandom), 4'($urandom), 0);
        add_request(REQ_INSERT, 16'h5A5A, 8'hA5, 4'h8, 0);
        add_request(REQ_POP,    16'h0000, 8'h00, 4'h0, 0);

        // random: fill and drain bursts reach full and empty, mixed ones wander
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            if (made == 0)
            begin
                mode = 0;
                seg_len = 45;
            end
            else if (made == 45)
            begin
                mode = 1;
                seg_len = 50;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                seg_len = $urandom_range(10, 60);
            end
            case (mode)
                0:       ins_pct = 92;
                1:       ins_pct = 8;
                default: ins_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0:
                begin
                    prio_lo = 0;
                    prio_hi = 15;
                end
                1:
                begin
                    prio_lo = $urandom_range(0, 12);
                    prio_hi = prio_lo + 3;
                end
                default:
                begin
                    prio_lo = $urandom_range(0, 15);
                    prio_hi = prio_lo;
                end
            endcase
            for (int i = 0; i < seg_len && made < RANDOM_ITEMS; i++)
            begin
                is_ins = $urandom_range(0, 99) < ins_pct;
                add_request(is_ins ? REQ_INSERT : REQ_POP, 16'($urandom), 8'($urandom),
                            4'($urandom_range(prio_lo, prio_hi)),
                            made == RANDOM_ITEMS / 2);
                made++;
            end
        end
        total_items = pending_requests.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
